>>> rtl/core/cau_pkg.sv
// shared types and constants of the complex arithmetic unit
`timescale 1ns / 1ps
package cau_pkg;

  localparam int PART_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 8;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  // per-item control that rides along the divider stages
  typedef struct packed {
    logic       div;
    logic       dz;
    logic [1:0] neg;
    logic [1:0] ovf;
  } ctl_t;

endpackage

>>> rtl/core/cau_if.sv
// item channels of the complex arithmetic unit
`timescale 1ns / 1ps
interface cau_in_if #(
  parameter int PART_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   operation;
  logic signed [PART_WIDTH-1:0] a_real;
  logic signed [PART_WIDTH-1:0] a_imag;
  logic signed [PART_WIDTH-1:0] b_real;
  logic signed [PART_WIDTH-1:0] b_imag;

  modport source (output valid, operation, a_real, a_imag, b_real, b_imag, input ready);
  modport sink (input valid, operation, a_real, a_imag, b_real, b_imag, output ready);
endinterface

interface cau_out_if #(
  parameter int PART_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [PART_WIDTH-1:0] res_real;
  logic signed [PART_WIDTH-1:0] res_imag;
  logic                         div_by_zero;
  logic                         saturated;

  modport source (output valid, res_real, res_imag, div_by_zero, saturated, input ready);
  modport sink (input valid, res_real, res_imag, div_by_zero, saturated, output ready);
endinterface

>>> rtl/core/cau_mul.sv
// operand stage: partial products and sums or differences of the parts
`timescale 1ns / 1ps
module cau_mul import cau_pkg::*; #(
  parameter int PART_WIDTH = PART_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  output logic                           ready_o,
  input  logic [1:0]                     operation_i,
  input  logic signed [PART_WIDTH-1:0]   a_real_i,
  input  logic signed [PART_WIDTH-1:0]   a_imag_i,
  input  logic signed [PART_WIDTH-1:0]   b_real_i,
  input  logic signed [PART_WIDTH-1:0]   b_imag_i,
  output logic                           valid_o,
  input  logic                           ready_i,
  output op_e                            op_o,
  output logic signed [2*PART_WIDTH-1:0] p_rr_o,
  output logic signed [2*PART_WIDTH-1:0] p_ii_o,
  output logic signed [2*PART_WIDTH-1:0] p_ri_o,
  output logic signed [2*PART_WIDTH-1:0] p_ir_o,
  output logic signed [2*PART_WIDTH-1:0] p_bb_r_o,
  output logic signed [2*PART_WIDTH-1:0] p_bb_i_o,
  output logic signed [PART_WIDTH:0]     as_re_o,
  output logic signed [PART_WIDTH:0]     as_im_o
);

  localparam int PRW = 2 * PART_WIDTH;
  localparam int ASW = PART_WIDTH + 1;

  logic valid_q;
  logic signed [ASW-1:0] as_re_d, as_im_d;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;

  always_comb begin
    if (op_e'(operation_i) == OP_SUB) begin
      as_re_d = ASW'(a_real_i) - ASW'(b_real_i);
      as_im_d = ASW'(a_imag_i) - ASW'(b_imag_i);
    end else begin
      as_re_d = ASW'(a_real_i) + ASW'(b_real_i);
      as_im_d = ASW'(a_imag_i) + ASW'(b_imag_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      op_o     <= op_e'(operation_i);
      p_rr_o   <= PRW'(a_real_i) * PRW'(b_real_i);
      p_ii_o   <= PRW'(a_imag_i) * PRW'(b_imag_i);
      p_ri_o   <= PRW'(a_real_i) * PRW'(b_imag_i);
      p_ir_o   <= PRW'(a_imag_i) * PRW'(b_real_i);
      p_bb_r_o <= PRW'(b_real_i) * PRW'(b_real_i);
      p_bb_i_o <= PRW'(b_imag_i) * PRW'(b_imag_i);
      as_re_o  <= as_re_d;
      as_im_o  <= as_im_d;
    end
  end

endmodule

>>> rtl/core/cau_combine.sv
// combine stage: part sums, sign and magnitude, divisor
`timescale 1ns / 1ps
module cau_combine import cau_pkg::*; #(
  parameter int PART_WIDTH = PART_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    valid_i,
  output logic                                    ready_o,
  input  op_e                                     op_i,
  input  logic signed [2*PART_WIDTH-1:0]          p_rr_i,
  input  logic signed [2*PART_WIDTH-1:0]          p_ii_i,
  input  logic signed [2*PART_WIDTH-1:0]          p_ri_i,
  input  logic signed [2*PART_WIDTH-1:0]          p_ir_i,
  input  logic signed [2*PART_WIDTH-1:0]          p_bb_r_i,
  input  logic signed [2*PART_WIDTH-1:0]          p_bb_i_i,
  input  logic signed [PART_WIDTH:0]              as_re_i,
  input  logic signed [PART_WIDTH:0]              as_im_i,
  output logic                                    valid_o,
  input  logic                                    ready_i,
  output ctl_t                                    ctl_o,
  output logic [2*PART_WIDTH+FRAC_BITS:0]         rem_o [2],
  output logic [PART_WIDTH:0]                     q_o [2],
  output logic [2*PART_WIDTH:0]                   den_o
);

  localparam int SW = 2 * PART_WIDTH + 1;
  localparam int NW = SW + FRAC_BITS;

  logic              valid_q;
  logic signed [SW-1:0] sum_d [2];
  logic [SW-1:0]     mag_d [2];
  logic [SW-1:0]     den_d;
  ctl_t              ctl_d;
  logic [NW-1:0]     rem_d [2];

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;

  always_comb begin
    den_d = SW'(p_bb_r_i) + SW'(p_bb_i_i);
    unique case (op_i)
      OP_ADD, OP_SUB: begin
        sum_d[0] = SW'(as_re_i);
        sum_d[1] = SW'(as_im_i);
      end
      OP_MUL: begin
        sum_d[0] = SW'(p_rr_i) - SW'(p_ii_i);
        sum_d[1] = SW'(p_ri_i) + SW'(p_ir_i);
      end
      default: begin
        sum_d[0] = SW'(p_rr_i) + SW'(p_ii_i);
        sum_d[1] = SW'(p_ir_i) - SW'(p_ri_i);
      end
    endcase
    ctl_d.dz  = (op_i == OP_DIV) && (den_d == '0);
    ctl_d.div = (op_i == OP_DIV) && (den_d != '0);
    ctl_d.ovf = 2'b00;
    for (int p = 0; p < 2; p++) begin
      mag_d[p] = sum_d[p][SW-1] ? SW'(-sum_d[p]) : SW'(sum_d[p]);
      ctl_d.neg[p] = sum_d[p][SW-1] && !ctl_d.dz;
      if (ctl_d.dz) begin
        rem_d[p] = '0;
      end else if (ctl_d.div) begin
        rem_d[p] = NW'(mag_d[p]) << FRAC_BITS;
      end else if (op_i == OP_MUL) begin
        rem_d[p] = NW'(mag_d[p] >> FRAC_BITS);
      end else begin
        rem_d[p] = NW'(mag_d[p]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      ctl_o  <= ctl_d;
      rem_o  <= rem_d;
      q_o[0] <= '0;
      q_o[1] <= '0;
      den_o  <= den_d;
    end
  end

endmodule

>>> rtl/core/cau_div_step.sv
// one restoring division step for both parts of an item
`timescale 1ns / 1ps
module cau_div_step import cau_pkg::*; #(
  parameter int PART_WIDTH = PART_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int QBIT       = 0
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  output logic                            ready_o,
  input  ctl_t                            ctl_i,
  input  logic [2*PART_WIDTH+FRAC_BITS:0] rem_i [2],
  input  logic [PART_WIDTH:0]             q_i [2],
  input  logic [2*PART_WIDTH:0]           den_i,
  output logic                            valid_o,
  input  logic                            ready_i,
  output ctl_t                            ctl_o,
  output logic [2*PART_WIDTH+FRAC_BITS:0] rem_o [2],
  output logic [PART_WIDTH:0]             q_o [2],
  output logic [2*PART_WIDTH:0]           den_o
);

  localparam int MW = 2 * PART_WIDTH + 1;
  localparam int NW = MW + FRAC_BITS;
  localparam int CW = NW + PART_WIDTH + 2;

  logic          valid_q;
  logic [CW-1:0] dsh;
  logic [CW-1:0] dtop;
  logic [CW-1:0] diff [2];
  logic          hit [2];
  ctl_t          ctl_d;
  logic [NW-1:0] rem_d [2];
  logic [PART_WIDTH:0] q_d [2];

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;

  always_comb begin
    dsh   = CW'(den_i) << QBIT;
    dtop  = CW'(den_i) << (PART_WIDTH + 1);
    ctl_d = ctl_i;
    for (int p = 0; p < 2; p++) begin
      diff[p]  = CW'(rem_i[p]) - dsh;
      hit[p]   = ctl_i.div && (CW'(rem_i[p]) >= dsh);
      rem_d[p] = hit[p] ? NW'(diff[p]) : rem_i[p];
      q_d[p]   = q_i[p];
      q_d[p][QBIT] = hit[p];
      // top step also flags a quotient too large for the result bits
      if (QBIT == PART_WIDTH) begin
        ctl_d.ovf[p] = ctl_i.div && (CW'(rem_i[p]) >= dtop);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      ctl_o <= ctl_d;
      rem_o <= rem_d;
      q_o   <= q_d;
      den_o <= den_i;
    end
  end

endmodule

>>> rtl/core/cau_clip.sv
// output stage: saturation to the part range and result register
`timescale 1ns / 1ps
module cau_clip import cau_pkg::*; #(
  parameter int PART_WIDTH = PART_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  output logic                            ready_o,
  input  ctl_t                            ctl_i,
  input  logic [2*PART_WIDTH+FRAC_BITS:0] rem_i [2],
  input  logic [PART_WIDTH:0]             q_i [2],
  output logic                            valid_o,
  input  logic                            ready_i,
  output logic signed [PART_WIDTH-1:0]    res_real_o,
  output logic signed [PART_WIDTH-1:0]    res_imag_o,
  output logic                            div_by_zero_o,
  output logic                            saturated_o
);

  localparam int NW = 2 * PART_WIDTH + 1 + FRAC_BITS;
  localparam logic [NW-1:0] HALF = NW'(1) << (PART_WIDTH - 1);
  localparam logic [PART_WIDTH-1:0] MAXV = {1'b0, {(PART_WIDTH-1){1'b1}}};
  localparam logic [PART_WIDTH-1:0] MINV = {1'b1, {(PART_WIDTH-1){1'b0}}};

  logic                  valid_q;
  logic [NW-1:0]         val [2];
  logic                  clip [2];
  logic [PART_WIDTH-1:0] part_d [2];

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;

  always_comb begin
    for (int p = 0; p < 2; p++) begin
      val[p] = ctl_i.div ? NW'(q_i[p]) : rem_i[p];
      if (ctl_i.neg[p]) begin
        clip[p]   = (ctl_i.div && ctl_i.ovf[p]) || (val[p] > HALF);
        part_d[p] = clip[p] ? MINV : PART_WIDTH'(-val[p]);
      end else begin
        clip[p]   = (ctl_i.div && ctl_i.ovf[p]) || (val[p] > HALF - NW'(1));
        part_d[p] = clip[p] ? MAXV : val[p][PART_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      res_real_o    <= part_d[0];
      res_imag_o    <= part_d[1];
      div_by_zero_o <= ctl_i.dz;
      saturated_o   <= clip[0] || clip[1];
    end
  end

endmodule

>>> rtl/core/complex_arith_unit.sv
// Complex ALU on signed fixed-point parts (Q8.8 by default): add, subtract, multiply
// and divide A by B, one result item per input item, in item order. It takes one item
// every cycle while the output is not stalled; an item passes through registers for
// the operand products, part sums, PART_WIDTH + 1 restoring quotient steps and the
// output clip, each divider stage settling one quotient bit. Every stage holds its
// item only while the next one is full and stalled, so bubbles close up under
// backpressure. Rounding is toward zero; a divide by a zero magnitude gives zeros
// with div_by_zero set; results that leave the part range saturate and set saturated.
`timescale 1ns / 1ps
module complex_arith_unit import cau_pkg::*; #(
  parameter int PART_WIDTH = PART_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cau_in_if.sink     in_i,
  cau_out_if.source  out_o
);

  localparam int PRW = 2 * PART_WIDTH;
  localparam int MW  = PRW + 1;
  localparam int NW  = MW + FRAC_BITS;
  localparam int NS  = PART_WIDTH + 2;

  logic                  m_valid, m_ready;
  op_e                   m_op;
  logic signed [PRW-1:0] m_rr, m_ii, m_ri, m_ir, m_bbr, m_bbi;
  logic signed [PART_WIDTH:0] m_as_re, m_as_im;

  logic                  s_valid [NS];
  logic                  s_ready [NS];
  ctl_t                  s_ctl [NS];
  logic [NW-1:0]         s_rem [NS][2];
  logic [PART_WIDTH:0]   s_q [NS][2];
  logic [MW-1:0]         s_den [NS];

  cau_mul #(.PART_WIDTH(PART_WIDTH)) u_mul (
    .clk_i, .rst_ni,
    .valid_i(in_i.valid), .ready_o(in_i.ready),
    .operation_i(in_i.operation),
    .a_real_i(in_i.a_real), .a_imag_i(in_i.a_imag),
    .b_real_i(in_i.b_real), .b_imag_i(in_i.b_imag),
    .valid_o(m_valid), .ready_i(m_ready), .op_o(m_op),
    .p_rr_o(m_rr), .p_ii_o(m_ii), .p_ri_o(m_ri), .p_ir_o(m_ir),
    .p_bb_r_o(m_bbr), .p_bb_i_o(m_bbi), .as_re_o(m_as_re), .as_im_o(m_as_im)
  );

  cau_combine #(.PART_WIDTH(PART_WIDTH), .FRAC_BITS(FRAC_BITS)) u_combine (
    .clk_i, .rst_ni,
    .valid_i(m_valid), .ready_o(m_ready), .op_i(m_op),
    .p_rr_i(m_rr), .p_ii_i(m_ii), .p_ri_i(m_ri), .p_ir_i(m_ir),
    .p_bb_r_i(m_bbr), .p_bb_i_i(m_bbi), .as_re_i(m_as_re), .as_im_i(m_as_im),
    .valid_o(s_valid[0]), .ready_i(s_ready[0]), .ctl_o(s_ctl[0]),
    .rem_o(s_rem[0]), .q_o(s_q[0]), .den_o(s_den[0])
  );

  for (genvar k = 0; k < NS - 1; k++) begin : g_step
    cau_div_step #(
      .PART_WIDTH(PART_WIDTH), .FRAC_BITS(FRAC_BITS), .QBIT(PART_WIDTH - k)
    ) u_step (
      .clk_i, .rst_ni,
      .valid_i(s_valid[k]), .ready_o(s_ready[k]), .ctl_i(s_ctl[k]),
      .rem_i(s_rem[k]), .q_i(s_q[k]), .den_i(s_den[k]),
      .valid_o(s_valid[k+1]), .ready_i(s_ready[k+1]), .ctl_o(s_ctl[k+1]),
      .rem_o(s_rem[k+1]), .q_o(s_q[k+1]), .den_o(s_den[k+1])
    );
  end

  cau_clip #(.PART_WIDTH(PART_WIDTH), .FRAC_BITS(FRAC_BITS)) u_clip (
    .clk_i, .rst_ni,
    .valid_i(s_valid[NS-1]), .ready_o(s_ready[NS-1]), .ctl_i(s_ctl[NS-1]),
    .rem_i(s_rem[NS-1]), .q_i(s_q[NS-1]),
    .valid_o(out_o.valid), .ready_i(out_o.ready),
    .res_real_o(out_o.res_real), .res_imag_o(out_o.res_imag),
    .div_by_zero_o(out_o.div_by_zero), .saturated_o(out_o.saturated)
  );

`ifndef SYNTHESIS
  localparam logic [PART_WIDTH-1:0] MAXV = {1'b0, {(PART_WIDTH-1){1'b1}}};
  localparam logic [PART_WIDTH-1:0] MINV = {1'b1, {(PART_WIDTH-1){1'b0}}};

  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.div_by_zero |-> out_o.res_real == '0 && out_o.res_imag == '0)
    else $error("divide by zero item with nonzero parts");

  a_dz_nosat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !(out_o.div_by_zero && out_o.saturated))
    else $error("divide by zero item flagged saturated");

  a_sat_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.saturated |->
      out_o.res_real == MAXV || out_o.res_real == MINV ||
      out_o.res_imag == MAXV || out_o.res_imag == MINV)
    else $error("saturated item without a clipped part");

  a_div_ctl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_valid[0] |-> !(s_ctl[0].div && s_ctl[0].dz))
    else $error("item marked both divide and divide by zero");
`endif

endmodule
